### src/dda_line_rasterizer_core_assert.svh
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// Both macros expect signals named clk and rst_n in the using module.

// The consequent holds in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dda rasterizer assertion failed");

// The consequent holds in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dda rasterizer assertion failed");

`endif

### src/dda_pkg.sv
package dda_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = COORD_BITS + FRAC_BITS;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int STEP_W     = QUO_W + 1;
    localparam int REM_W      = COORD_BITS + 1;
    localparam int CNT_W      = $clog2(FRAC_BITS + 1);

    // The queue depth must stay a power of two so that the pointers wrap.
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [POS_W-1:0] HALF_PIXEL = POS_W'(1) << (FRAC_BITS - 1);

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_NEXT  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] abs_dx;
        logic [COORD_BITS-1:0] abs_dy;
        logic [COORD_BITS-1:0] steps;
        logic                  neg_x;
        logic                  neg_y;
    } cmd_t;

    function automatic logic [COORD_BITS-1:0] pixel_of(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] rounded;
        rounded = pos + HALF_PIXEL;
        return rounded[POS_W-1:FRAC_BITS];
    endfunction

endpackage

### src/dda_cmd_if.sv
interface dda_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [dda_pkg::COORD_BITS-1:0] x_start;
    logic [dda_pkg::COORD_BITS-1:0] y_start;
    logic [dda_pkg::COORD_BITS-1:0] x_end;
    logic [dda_pkg::COORD_BITS-1:0] y_end;

    modport source (output valid, output kind, output x_start, output y_start,
                    output x_end, output y_end, input ready);
    modport sink (input valid, input kind, input x_start, input y_start,
                  input x_end, input y_end, output ready);
endinterface

### src/dda_pix_if.sv
interface dda_pix_if;
    logic                           valid;
    logic                           ready;
    logic [dda_pkg::COORD_BITS-1:0] pixel_x;
    logic [dda_pkg::COORD_BITS-1:0] pixel_y;
    logic                           last;

    modport source (output valid, output pixel_x, output pixel_y, output last,
                    input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input last,
                  output ready);
endinterface

### src/dda_line_rasterizer_core.sv
// Channel  Role     Payload
// cmd      sink     kind, x_start, y_start, x_end, y_end
// pix      source   pixel_x, pixel_y, last
//
// A next-pixel item for an active line emits one pixel per cycle while pix is
// ready.
// A start item emits its start pixel, then, unless the line has no steps, holds
// the back end in ST_DIV while the restoring divider forms both increments.
// A two-entry queue lets cmd keep accepting items while the back end divides or
// pix stalls. Reset is asynchronous and leaves no line active.
module dda_line_rasterizer_core (
    input  logic        clk,
    input  logic        rst_n,
    dda_cmd_if.sink     cmd,
    dda_pix_if.source   pix
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    dda_pkg::cmd_t   q_entry;
    dda_pkg::cmd_t   q_head;

    dda_front u_front (
        .cmd     (cmd),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    dda_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_entry),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    dda_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pix     (pix)
    );

endmodule

### src/dda_front.sv
module dda_front (
    dda_cmd_if.sink         cmd,
    input  logic            q_full,
    output logic            q_push,
    output dda_pkg::cmd_t   q_entry
);

    logic                           neg_x;
    logic                           neg_y;
    logic [dda_pkg::COORD_BITS-1:0] abs_dx;
    logic [dda_pkg::COORD_BITS-1:0] abs_dy;

    assign cmd.ready = !q_full;
    assign q_push    = cmd.valid && !q_full;

    always_comb
    begin
        neg_x  = cmd.x_end < cmd.x_start;
        neg_y  = cmd.y_end < cmd.y_start;
        abs_dx = neg_x ? (cmd.x_start - cmd.x_end) : (cmd.x_end - cmd.x_start);
        abs_dy = neg_y ? (cmd.y_start - cmd.y_end) : (cmd.y_end - cmd.y_start);

        q_entry.kind    = dda_pkg::kind_t'(cmd.kind);
        q_entry.x_start = cmd.x_start;
        q_entry.y_start = cmd.y_start;
        q_entry.abs_dx  = abs_dx;
        q_entry.abs_dy  = abs_dy;
        q_entry.steps   = (abs_dx > abs_dy) ? abs_dx : abs_dy;
        q_entry.neg_x   = neg_x;
        q_entry.neg_y   = neg_y;
    end

endmodule

### src/dda_queue.sv
module dda_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dda_pkg::cmd_t   din,
    output logic            full,
    input  logic            pop,
    output dda_pkg::cmd_t   dout,
    output logic            empty
);

    dda_pkg::cmd_t                entry_reg [dda_pkg::Q_DEPTH];
    logic [dda_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [dda_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [dda_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [dda_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [dda_pkg::QCNT_W-1:0]   count_reg;
    logic [dda_pkg::QCNT_W-1:0]   count_next;

    assign full  = count_reg == dda_pkg::QCNT_W'(dda_pkg::Q_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### src/dda_back.sv
`include "dda_line_rasterizer_core_assert.svh"

module dda_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  dda_pkg::cmd_t   q_head,
    output logic            q_pop,
    dda_pix_if.source       pix
);

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_DIV   = 2'b10
    } back_state_t;

    back_state_t                    state_reg;
    back_state_t                    state_next;
    logic [dda_pkg::POS_W-1:0]      pos_x_reg;
    logic [dda_pkg::POS_W-1:0]      pos_x_next;
    logic [dda_pkg::POS_W-1:0]      pos_y_reg;
    logic [dda_pkg::POS_W-1:0]      pos_y_next;
    logic [dda_pkg::STEP_W-1:0]     step_x_reg;
    logic [dda_pkg::STEP_W-1:0]     step_x_next;
    logic [dda_pkg::STEP_W-1:0]     step_y_reg;
    logic [dda_pkg::STEP_W-1:0]     step_y_next;
    logic [dda_pkg::COORD_BITS-1:0] steps_left_reg;
    logic [dda_pkg::COORD_BITS-1:0] steps_left_next;
    logic [dda_pkg::REM_W-1:0]      rem_x_reg;
    logic [dda_pkg::REM_W-1:0]      rem_x_next;
    logic [dda_pkg::REM_W-1:0]      rem_y_reg;
    logic [dda_pkg::REM_W-1:0]      rem_y_next;
    logic [dda_pkg::QUO_W-1:0]      quo_x_reg;
    logic [dda_pkg::QUO_W-1:0]      quo_x_next;
    logic [dda_pkg::QUO_W-1:0]      quo_y_reg;
    logic [dda_pkg::QUO_W-1:0]      quo_y_next;
    logic                           neg_x_reg;
    logic                           neg_x_next;
    logic                           neg_y_reg;
    logic                           neg_y_next;
    logic [dda_pkg::CNT_W-1:0]      cnt_reg;
    logic [dda_pkg::CNT_W-1:0]      cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [dda_pkg::COORD_BITS-1:0] out_x_reg;
    logic [dda_pkg::COORD_BITS-1:0] out_x_next;
    logic [dda_pkg::COORD_BITS-1:0] out_y_reg;
    logic [dda_pkg::COORD_BITS-1:0] out_y_next;
    logic                           out_last_reg;
    logic                           out_last_next;

    logic                           slot_free;
    logic                           is_start;
    logic                           line_active;
    logic [dda_pkg::POS_W-1:0]      sum_x;
    logic [dda_pkg::POS_W-1:0]      sum_y;
    logic [dda_pkg::COORD_BITS-1:0] steps_dec;
    logic [dda_pkg::REM_W-1:0]      divisor;
    logic                           ge_x;
    logic                           ge_y;
    logic [dda_pkg::REM_W-1:0]      diff_x;
    logic [dda_pkg::REM_W-1:0]      diff_y;
    logic [dda_pkg::QUO_W-1:0]      quo_x_fin;
    logic [dda_pkg::QUO_W-1:0]      quo_y_fin;
    logic [dda_pkg::STEP_W-1:0]     mag_x;
    logic [dda_pkg::STEP_W-1:0]     mag_y;

    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = out_x_reg;
    assign pix.pixel_y = out_y_reg;
    assign pix.last    = out_last_reg;

    assign slot_free   = !out_valid_reg || pix.ready;
    assign is_start    = q_head.kind == dda_pkg::KIND_START;
    assign line_active = steps_left_reg != '0;
    assign q_pop       = (state_reg == ST_READY) && !q_empty && slot_free;

    // The increment magnitude is at most one pixel, so it is sign-extended into
    // the position width and the sum wraps back into range.
    assign sum_x = pos_x_reg
                 + {{(dda_pkg::POS_W - dda_pkg::STEP_W){step_x_reg[dda_pkg::STEP_W-1]}},
                    step_x_reg};
    assign sum_y = pos_y_reg
                 + {{(dda_pkg::POS_W - dda_pkg::STEP_W){step_y_reg[dda_pkg::STEP_W-1]}},
                    step_y_reg};
    assign steps_dec = steps_left_reg - 1'b1;

    // Restoring division, one quotient bit per cycle. The remainder stays below
    // the divisor, so doubling it never leaves the remainder width.
    assign divisor   = {1'b0, steps_left_reg};
    assign ge_x      = rem_x_reg >= divisor;
    assign ge_y      = rem_y_reg >= divisor;
    assign diff_x    = ge_x ? (rem_x_reg - divisor) : rem_x_reg;
    assign diff_y    = ge_y ? (rem_y_reg - divisor) : rem_y_reg;
    assign quo_x_fin = {quo_x_reg[dda_pkg::QUO_W-2:0], ge_x};
    assign quo_y_fin = {quo_y_reg[dda_pkg::QUO_W-2:0], ge_y};
    assign mag_x     = {1'b0, quo_x_fin};
    assign mag_y     = {1'b0, quo_y_fin};

    always_comb
    begin
        state_next      = state_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        steps_left_next = steps_left_reg;
        rem_x_next      = rem_x_reg;
        rem_y_next      = rem_y_reg;
        quo_x_next      = quo_x_reg;
        quo_y_next      = quo_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !pix.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_READY:
            begin
                if (q_pop)
                begin
                    if (is_start)
                    begin
                        pos_x_next     = {q_head.x_start, {dda_pkg::FRAC_BITS{1'b0}}};
                        pos_y_next     = {q_head.y_start, {dda_pkg::FRAC_BITS{1'b0}}};
                        out_valid_next = 1'b1;
                        out_x_next     = q_head.x_start;
                        out_y_next     = q_head.y_start;
                        step_x_next    = '0;
                        step_y_next    = '0;
                        steps_left_next = q_head.steps;
                        if (q_head.steps == '0)
                        begin
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            out_last_next = 1'b0;
                            rem_x_next    = {1'b0, q_head.abs_dx};
                            rem_y_next    = {1'b0, q_head.abs_dy};
                            neg_x_next    = q_head.neg_x;
                            neg_y_next    = q_head.neg_y;
                            cnt_next      = dda_pkg::CNT_W'(dda_pkg::FRAC_BITS);
                            state_next    = ST_DIV;
                        end
                    end
                    else if (line_active)
                    begin
                        pos_x_next      = sum_x;
                        pos_y_next      = sum_y;
                        steps_left_next = steps_dec;
                        out_valid_next  = 1'b1;
                        out_x_next      = dda_pkg::pixel_of(sum_x);
                        out_y_next      = dda_pkg::pixel_of(sum_y);
                        out_last_next   = steps_dec == '0;
                    end
                end
            end
            ST_DIV:
            begin
                rem_x_next = {diff_x[dda_pkg::COORD_BITS-1:0], 1'b0};
                rem_y_next = {diff_y[dda_pkg::COORD_BITS-1:0], 1'b0};
                quo_x_next = quo_x_fin;
                quo_y_next = quo_y_fin;
                if (cnt_reg == '0)
                begin
                    step_x_next = neg_x_reg ? (~mag_x + 1'b1) : mag_x;
                    step_y_next = neg_y_reg ? (~mag_y + 1'b1) : mag_y;
                    state_next  = ST_READY;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_READY;
            steps_left_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        step_x_reg   <= step_x_next;
        step_y_reg   <= step_y_next;
        rem_x_reg    <= rem_x_next;
        rem_y_reg    <= rem_y_next;
        quo_x_reg    <= quo_x_next;
        quo_y_reg    <= quo_y_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    `DDA_ASSERT_NEXT(a_div_ends, (state_reg == ST_DIV) && (cnt_reg == '0), state_reg == ST_READY)
    `DDA_ASSERT_SAME(a_div_has_line, state_reg == ST_DIV, steps_left_reg != '0)
    `DDA_ASSERT_NEXT(a_next_counts_down, q_pop && !is_start && line_active, steps_left_reg == $past(steps_dec))

endmodule
